FILE: design/cooperative_task_tick_scheduler_assert.svh
// Assertion macros for the task tick scheduler.
// Used by the top level; the enclosing module supplies clk and rst_n.
`ifndef COOPERATIVE_TASK_TICK_SCHEDULER_ASSERT_SVH
`define COOPERATIVE_TASK_TICK_SCHEDULER_ASSERT_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define CTTS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset.
`define CTTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/ctts_pkg.sv
// Shared types and constants of the task tick scheduler.
// Used by the controller, the datapath and the top level; depends on nothing.
package ctts_pkg;

  localparam int REQ_W      = 2;
  localparam int SLOT_W     = 3;
  localparam int TASK_W     = 8;
  localparam int TIME_W     = 16;
  localparam int PEND_W     = 8;
  localparam int MAX_OUT    = 8;
  localparam int CNT_W      = 3;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 16;

  localparam logic [PEND_W-1:0] PEND_MAX = 8'hFF;

  typedef enum logic [REQ_W-1:0] {
    REQ_CREATE   = 2'd0,
    REQ_DELETE   = 2'd1,
    REQ_TICK     = 2'd2,
    REQ_DISPATCH = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CREATE,
    ST_REPLY,
    ST_WALK
  } ctl_state_t;

  // One entry of the task table memory.
  typedef struct packed {
    logic [TASK_W-1:0] task_id;
    logic [TIME_W-1:0] countdown;
    logic [TIME_W-1:0] reload;
    logic [PEND_W-1:0] pending;
  } rec_t;

  typedef struct packed {
    logic load_req;
    logic idx_inc;
    logic do_create;
    logic emit_fail;
    logic do_delete;
    logic emit_none;
    logic walk_adv;
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic free_here;
    logic scan_end;
    logic any_ready;
    logic ex_emit;
    logic ex_last;
    logic walk_done;
    logic out_free;
  } sts_t;

endpackage

FILE: design/ctts_ctrl.sv
// Controller state machine of the task tick scheduler.
// Depends on ctts_pkg; drives the datapath by command and reads its status.
module ctts_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  ctts_pkg::req_t in_req,
  input  ctts_pkg::sts_t sts,
  output ctts_pkg::cmd_t cmd
);
  import ctts_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_req = 1'b1;
          unique case (in_req)
            REQ_CREATE:   state_nxt = ST_CREATE;
            REQ_DELETE:   state_nxt = ST_REPLY;
            REQ_TICK:     state_nxt = ST_WALK;
            REQ_DISPATCH: state_nxt = sts.any_ready ? ST_WALK : ST_REPLY;
          endcase
        end
      end
      ST_CREATE: begin
        priority if (sts.free_here) begin
          if (sts.out_free) begin
            cmd.do_create = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else if (sts.scan_end) begin
          state_nxt = ST_REPLY;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ST_REPLY: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
          unique case (sts.req)
            REQ_CREATE:   cmd.emit_fail = 1'b1;
            REQ_DELETE:   cmd.do_delete = 1'b1;
            REQ_DISPATCH: cmd.emit_none = 1'b1;
            REQ_TICK:     cmd.emit_none = 1'b0;
          endcase
        end
      end
      ST_WALK: begin
        priority if (sts.walk_done) begin
          state_nxt = ST_IDLE;
        end else if (sts.ex_emit) begin
          if (sts.out_free) begin
            cmd.walk_adv = 1'b1;
            if (sts.ex_last) begin
              state_nxt = ST_IDLE;
            end
          end
        end else begin
          cmd.walk_adv = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

FILE: design/ctts_datapath.sv
// Datapath of the task tick scheduler: request register, slot flags, table
// memory, walk pipeline and output register. Depends on ctts_pkg.
module ctts_datapath #(
  parameter int SLOTS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ctts_pkg::cmd_t                      cmd,
  output ctts_pkg::sts_t                      sts,
  input  logic [ctts_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic [ctts_pkg::REQ_W-1:0]          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ctts_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                out_tuser,
  output logic                                out_tlast
);
  import ctts_pkg::*;

  localparam int IDXW = $clog2(SLOTS);
  localparam int SW   = (IDXW > SLOT_W) ? IDXW : SLOT_W;

  function automatic logic [SLOT_W-1:0] to_slot(input logic [IDXW-1:0] i);
    logic [SW-1:0] w;
    w = SW'(i);
    return w[SLOT_W-1:0];
  endfunction

  // Request register.
  req_t              req_r;
  logic [SLOT_W-1:0] req_slot_r;
  logic [TASK_W-1:0] req_task_r;
  logic [TIME_W-1:0] req_dly_r;
  logic [TIME_W-1:0] req_per_r;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r      <= req_t'(in_tuser);
      req_slot_r <= in_tdata[SLOT_W-1:0];
      req_task_r <= in_tdata[SLOT_W+TASK_W-1:SLOT_W];
      req_dly_r  <= in_tdata[SLOT_W+TASK_W+TIME_W-1:SLOT_W+TASK_W];
      req_per_r  <= in_tdata[SLOT_W+TASK_W+2*TIME_W-1:SLOT_W+TASK_W+TIME_W];
    end
  end

  // Slot flags: a slot is ready when it is valid and has a pending run.
  logic [SLOTS-1:0] valid_r;
  logic [SLOTS-1:0] ready_r;

  // Scan and walk control.
  logic [IDXW-1:0]  scan_idx_r;
  logic [IDXW:0]    rd_idx_r;
  logic             ex_vld_r;
  logic [IDXW-1:0]  ex_idx_r;
  logic [CNT_W-1:0] cnt_r;
  logic             rd_in_range;

  assign rd_in_range = rd_idx_r < (IDXW+1)'(SLOTS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_vld_r <= 1'b0;
    end else if (cmd.load_req) begin
      ex_vld_r <= 1'b0;
    end else if (cmd.walk_adv) begin
      ex_vld_r <= rd_in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      scan_idx_r <= '0;
      rd_idx_r   <= '0;
      cnt_r      <= '0;
    end else begin
      if (cmd.idx_inc) begin
        scan_idx_r <= scan_idx_r + 1'b1;
      end
      if (cmd.walk_adv) begin
        if (rd_in_range) begin
          ex_idx_r <= rd_idx_r[IDXW-1:0];
          rd_idx_r <= rd_idx_r + 1'b1;
        end
        if (sts.ex_emit) begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  // Task table memory, one write and one read port, registered read data.
  rec_t            mem [SLOTS];
  rec_t            rd_data_r;
  logic            mem_we;
  logic [IDXW-1:0] mem_waddr;
  rec_t            mem_wdata;
  logic            mem_re;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[rd_idx_r[IDXW-1:0]];
    end
  end

  assign mem_re = cmd.walk_adv && rd_in_range;

  // Execute stage of the walk.
  rec_t tick_rec;
  rec_t disp_rec;
  logic tick_fire;
  logic ex_tick;
  logic ex_emit;
  logic above;

  always_comb begin
    tick_rec  = rd_data_r;
    tick_fire = 1'b0;
    if (rd_data_r.countdown > TIME_W'(1)) begin
      tick_rec.countdown = rd_data_r.countdown - 1'b1;
    end else if (rd_data_r.countdown == TIME_W'(1)) begin
      tick_fire          = 1'b1;
      tick_rec.countdown = rd_data_r.reload;
      if (rd_data_r.pending != PEND_MAX) begin
        tick_rec.pending = rd_data_r.pending + 1'b1;
      end
    end
    disp_rec         = rd_data_r;
    disp_rec.pending = rd_data_r.pending - 1'b1;
  end

  assign ex_tick = ex_vld_r && (req_r == REQ_TICK) && valid_r[ex_idx_r];
  assign ex_emit = ex_vld_r && (req_r == REQ_DISPATCH) && ready_r[ex_idx_r];

  // Any ready slot after the one in the execute stage.
  always_comb begin
    above = 1'b0;
    for (int j = 0; j < SLOTS; j++) begin
      if (ready_r[j] && (int'(ex_idx_r) < j)) begin
        above = 1'b1;
      end
    end
  end

  // Delete check.
  logic [SW-1:0]   del_wide;
  logic [IDXW-1:0] del_idx;
  logic            del_ok;

  assign del_wide = SW'(req_slot_r);
  assign del_idx  = del_wide[IDXW-1:0];
  assign del_ok   = (int'(req_slot_r) < SLOTS) && valid_r[del_idx];

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ex_idx_r;
    mem_wdata = tick_rec;
    if (cmd.do_create) begin
      mem_we            = 1'b1;
      mem_waddr         = scan_idx_r;
      mem_wdata.task_id   = req_task_r;
      mem_wdata.countdown = req_dly_r;
      mem_wdata.reload    = req_per_r;
      mem_wdata.pending   = PEND_W'(1);
    end else if (cmd.walk_adv && ex_tick) begin
      mem_we = 1'b1;
    end else if (cmd.walk_adv && ex_emit) begin
      mem_we    = 1'b1;
      mem_wdata = disp_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      ready_r <= '0;
    end else begin
      if (cmd.do_create) begin
        valid_r[scan_idx_r] <= 1'b1;
        ready_r[scan_idx_r] <= 1'b1;
      end
      if (cmd.do_delete && del_ok) begin
        valid_r[del_idx] <= 1'b0;
        ready_r[del_idx] <= 1'b0;
      end
      if (cmd.walk_adv && ex_tick && tick_fire) begin
        ready_r[ex_idx_r] <= 1'b1;
      end
      if (cmd.walk_adv && ex_emit) begin
        ready_r[ex_idx_r] <= (rd_data_r.pending != PEND_W'(1));
      end
    end
  end

  // Output register.
  logic                  out_valid_r;
  logic                  res_status_nxt;
  logic [SLOT_W-1:0]     res_slot_nxt;
  logic [TASK_W-1:0]     res_task_nxt;
  logic                  res_none_nxt;
  logic                  res_last_nxt;
  logic                  out_load;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_none_r;
  logic                  out_last_r;

  assign out_load = cmd.do_create || cmd.emit_fail || cmd.do_delete || cmd.emit_none
                    || (cmd.walk_adv && ex_emit);

  always_comb begin
    res_status_nxt = 1'b0;
    res_slot_nxt   = '0;
    res_task_nxt   = '0;
    res_none_nxt   = 1'b0;
    res_last_nxt   = 1'b1;
    priority if (cmd.do_create) begin
      res_slot_nxt = to_slot(scan_idx_r);
    end else if (cmd.emit_fail) begin
      res_status_nxt = 1'b1;
    end else if (cmd.do_delete) begin
      res_status_nxt = !del_ok;
      res_slot_nxt   = req_slot_r;
    end else if (cmd.emit_none) begin
      res_none_nxt = 1'b1;
    end else begin
      res_slot_nxt = to_slot(ex_idx_r);
      res_task_nxt = rd_data_r.task_id;
      res_last_nxt = (cnt_r == CNT_W'(MAX_OUT-1)) || !above;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= OUT_DATA_W'({res_task_nxt, res_slot_nxt, res_status_nxt});
      out_none_r <= res_none_nxt;
      out_last_r <= res_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_none_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    sts           = '0;
    sts.req       = req_r;
    sts.free_here = !valid_r[scan_idx_r];
    sts.scan_end  = scan_idx_r == IDXW'(SLOTS-1);
    sts.any_ready = |ready_r;
    sts.ex_emit   = ex_emit;
    sts.ex_last   = res_last_nxt;
    sts.walk_done = !ex_vld_r && !rd_in_range;
    sts.out_free  = !out_valid_r || out_tready;
  end

endmodule

FILE: design/cooperative_task_tick_scheduler.sv
// Cooperative task tick scheduler, top level: controller plus datapath.
// Depends on ctts_pkg, ctts_ctrl, ctts_datapath and the assertion header.
//
// A request arrives on the in_ stream: create a task in the lowest free slot,
// delete a slot, tick every countdown, or dispatch the ready tasks. Create
// and delete answer with one result; a tick answers with none; a dispatch
// answers with one result per slot that has a pending run (at most eight,
// in slot order), or with one result flagged in out_tuser when none is ready.
// out_tlast marks the final result of each request.
// A create scans the valid flags from slot 0 up to the first free slot and
// fails on a full table; tick and dispatch walk the task table memory at one
// slot per cycle on its single read port, but for a result that waits on the
// output.
// in_tready is high only while no request is in work; a request is taken
// while the last result of the previous one still sits in the output register.
// A stalled receiver holds the result in the output register and the walk
// waits on that slot until the transfer completes.
// Reset clears every slot at once through the valid flags; the table memory
// needs no clearing pass, and requests are taken from the first cycle on.
`include "cooperative_task_tick_scheduler_assert.svh"

module cooperative_task_tick_scheduler #(
  parameter int SLOTS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // slot [2:0], task_id [10:3], start_delay [26:11], reload_period [42:27]
  input  logic [ctts_pkg::IN_DATA_W-1:0]  in_tdata,
  // req_type [1:0]
  input  logic [ctts_pkg::REQ_W-1:0]      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // status [0], out_slot [3:1], out_task [11:4]
  output logic [ctts_pkg::OUT_DATA_W-1:0] out_tdata,
  // none_ready [0]
  output logic                            out_tuser,
  output logic                            out_tlast
);
  import ctts_pkg::*;

  cmd_t cmd;
  sts_t sts;
  req_t in_req;

  assign in_req = req_t'(in_tuser);

  ctts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_req    (in_req),
    .sts       (sts),
    .cmd       (cmd)
  );

  ctts_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // A request in work blocks the next one.
  `CTTS_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "accepted while busy")
  // The no-ready-task answer is a single, empty result.
  `CTTS_ASSERT_IMPL(a_none_form, out_tvalid && out_tuser, out_tlast && out_tdata == '0, "bad none")
  // While a result that is not the last one waits, its dispatch is still running.
  `CTTS_ASSERT_IMPL(a_dispatch_open, out_tvalid && !out_tlast, !in_tready, "dispatch ended early")

endmodule

FILE: tb/tb_cooperative_task_tick_scheduler.sv
`timescale 1ns / 100ps
// Self-checking testbench for the cooperative task tick scheduler.
// Streams create, delete, tick and dispatch requests into the block, predicts every
// result from a local copy of the slot table, and checks each output transfer.
// Depends on ctts_pkg and the scheduler RTL.
module tb_cooperative_task_tick_scheduler;
  import ctts_pkg::*;

  localparam int SLOTS       = 8;
  localparam int RANDOM_REQS = 128;
  localparam int CALM_TAIL   = 30;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    req_t              kind;
    logic [SLOT_W-1:0] slot;
    logic [TASK_W-1:0] task_id;
    logic [TIME_W-1:0] delay;
    logic [TIME_W-1:0] period;
  } sched_req_t;

  typedef struct {
    logic              status;
    logic [SLOT_W-1:0] slot;
    logic [TASK_W-1:0] task_id;
    logic              none_ready;
    logic              last;
  } sched_reply_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [REQ_W-1:0]      in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;

  // Local copy of the task table.
  logic              tbl_valid [SLOTS];
  logic [TASK_W-1:0] tbl_task  [SLOTS];
  logic [TIME_W-1:0] tbl_count [SLOTS];
  logic [TIME_W-1:0] tbl_reload[SLOTS];
  logic [PEND_W-1:0] tbl_pend  [SLOTS];

  sched_req_t   req_q[$];
  sched_reply_t sched_replies[$];
  sched_req_t   in_flight;
  sched_reply_t want;

  int in_gap = 0;
  int out_gap = 0;
  int n_errors = 0;
  int n_checked = 0;
  int n_accepted = 0;
  int kind_seen[4] = '{0, 0, 0, 0};
  int cycles = 0;

  cooperative_task_tick_scheduler #(.SLOTS(SLOTS)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void push_reply(logic st, int sl, logic [TASK_W-1:0] tk, logic nr,
                                     logic lst);
    sched_reply_t r;
    r.status     = st;
    r.slot       = SLOT_W'(sl);
    r.task_id    = tk;
    r.none_ready = nr;
    r.last       = lst;
    sched_replies.push_back(r);
  endfunction

  // Applies one accepted request to the table copy and queues its results.
  task automatic sched_apply(input sched_req_t r);
    int  n_ready;
    int  k;
    bit  placed;
    placed = 0;
    kind_seen[r.kind]++;
    case (r.kind)
      REQ_CREATE: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!placed && !tbl_valid[i]) begin
            tbl_valid[i]  = 1'b1;
            tbl_task[i]   = r.task_id;
            tbl_count[i]  = r.delay;
            tbl_reload[i] = r.period;
            tbl_pend[i]   = PEND_W'(1);
            push_reply(1'b0, i, '0, 1'b0, 1'b1);
            placed = 1;
          end
        end
        if (!placed) push_reply(1'b1, 0, '0, 1'b0, 1'b1);
      end
      REQ_DELETE: begin
        if (r.slot < SLOTS && tbl_valid[r.slot]) begin
          tbl_valid[r.slot]  = 1'b0;
          tbl_task[r.slot]   = '0;
          tbl_count[r.slot]  = '0;
          tbl_reload[r.slot] = '0;
          tbl_pend[r.slot]   = '0;
          push_reply(1'b0, r.slot, '0, 1'b0, 1'b1);
        end else begin
          push_reply(1'b1, r.slot, '0, 1'b0, 1'b1);
        end
      end
      REQ_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_valid[i]) begin
            if (tbl_count[i] > 1) begin
              tbl_count[i] = tbl_count[i] - 1'b1;
            end else if (tbl_count[i] == 1) begin
              if (tbl_pend[i] != PEND_MAX) tbl_pend[i] = tbl_pend[i] + 1'b1;
              tbl_count[i] = tbl_reload[i];
            end
          end
        end
      end
      default: begin
        // Count the ready slots first so that the final result carries last.
        n_ready = 0;
        for (int i = 0; i < SLOTS; i++)
          if (tbl_pend[i] != 0 && n_ready < MAX_OUT) n_ready++;
        if (n_ready == 0) begin
          push_reply(1'b0, 0, '0, 1'b1, 1'b1);
        end else begin
          k = 0;
          for (int i = 0; i < SLOTS; i++) begin
            if (tbl_pend[i] != 0 && k < n_ready) begin
              tbl_pend[i] = tbl_pend[i] - 1'b1;
              push_reply(1'b0, i, tbl_task[i], 1'b0, k == n_ready - 1);
              k++;
            end
          end
        end
      end
    endcase
  endtask

  function automatic void add_req(req_t k, int sl, int id, int dly, int per);
    sched_req_t r;
    r.kind    = k;
    r.slot    = SLOT_W'(sl);
    r.task_id = TASK_W'(id);
    r.delay   = TIME_W'(dly);
    r.period  = TIME_W'(per);
    req_q.push_back(r);
  endfunction

  // Mostly short times so that tasks fire often, with the extremes mixed in.
  function automatic int rand_time();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick <= 6) return $urandom_range(0, 4);
    if (pick == 7) return 16'hFFFF;
    if (pick == 8) return $urandom_range(0, 16'hFFFF);
    return 1;
  endfunction

  // Request driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= REQ_CREATE;
    end else begin
      if (in_tvalid && in_tready) begin
        sched_apply(in_flight);
        n_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (req_q.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
          in_gap = $urandom_range(0, 11);
          in_tvalid <= 1'b0;
        end else if (req_q.size() > 0) begin
          in_flight = req_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {5'b0, in_flight.period, in_flight.delay, in_flight.task_id,
                        in_flight.slot};
          in_tuser  <= in_flight.kind;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result receiver with random backpressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_tready <= 1'b0;
    end else if (req_q.size() > CALM_TAIL && $urandom_range(0, 6) == 0) begin
      out_gap = $urandom_range(0, 11);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Result monitor: each output transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      n_checked++;
      if (sched_replies.size() == 0) begin
        $error("unexpected result: tdata %h, tuser %b, tlast %b", out_tdata, out_tuser,
               out_tlast);
        n_errors++;
      end else begin
        want = sched_replies.pop_front();
        if (out_tdata[0] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tdata[0]);
          n_errors++;
        end
        if (out_tdata[3:1] !== want.slot) begin
          $error("out_slot: expected %0d, got %0d", want.slot, out_tdata[3:1]);
          n_errors++;
        end
        if (out_tdata[11:4] !== want.task_id) begin
          $error("out_task: expected %0d, got %0d", want.task_id, out_tdata[11:4]);
          n_errors++;
        end
        if (out_tuser !== want.none_ready) begin
          $error("none_ready: expected %0d, got %0d", want.none_ready, out_tuser);
          n_errors++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_tlast);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still awaited", cycles,
               sched_replies.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int pick;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_valid[i]  = 1'b0;
      tbl_task[i]   = '0;
      tbl_count[i]  = '0;
      tbl_reload[i] = '0;
      tbl_pend[i]   = '0;
    end

    // Directed part: empty table, full table, never-firing, one-shot and
    // periodic tasks, extreme field values, and failing deletes.
    add_req(REQ_DISPATCH, 0, 0, 0, 0);
    add_req(REQ_DELETE, 0, 0, 0, 0);
    add_req(REQ_CREATE, 0, 8'h00, 16'h0000, 16'h0000);
    add_req(REQ_CREATE, 7, 8'hFF, 16'hFFFF, 16'hFFFF);
    add_req(REQ_CREATE, 0, 8'hA5, 1, 0);
    add_req(REQ_CREATE, 0, 8'h5A, 2, 3);
    for (int i = 0; i < 4; i++) add_req(REQ_CREATE, i, 8'h10 + i, 1, 1);
    add_req(REQ_CREATE, 0, 8'h77, 5, 5);
    add_req(REQ_DISPATCH, 0, 0, 0, 0);
    add_req(REQ_TICK, 0, 0, 0, 0);
    add_req(REQ_TICK, 7, 8'hFF, 16'hFFFF, 16'hFFFF);
    add_req(REQ_DISPATCH, 7, 8'hFF, 16'hFFFF, 16'hFFFF);
    add_req(REQ_DELETE, 7, 0, 0, 0);
    add_req(REQ_DELETE, 7, 8'hFF, 16'hFFFF, 16'hFFFF);
    add_req(REQ_TICK, 0, 0, 0, 0);
    add_req(REQ_TICK, 0, 0, 0, 0);
    add_req(REQ_DISPATCH, 0, 0, 0, 0);
    add_req(REQ_CREATE, 2, 8'h3C, 16'h8000, 16'h0001);
    add_req(REQ_DELETE, 3, 0, 0, 0);
    add_req(REQ_CREATE, 5, 8'hC3, 16'h7FFF, 16'h8000);
    add_req(REQ_DISPATCH, 0, 0, 0, 0);
    add_req(REQ_DISPATCH, 0, 0, 0, 0);

    // Random part: a busy mix of requests with random content in every field.
    for (int n = 0; n < RANDOM_REQS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30)
        add_req(REQ_CREATE, $urandom_range(0, 7), $urandom_range(0, 255), rand_time(),
                rand_time());
      else if (pick < 50)
        add_req(REQ_DELETE, $urandom_range(0, 7), $urandom_range(0, 255),
                $urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF));
      else if (pick < 80)
        add_req(REQ_TICK, $urandom_range(0, 7), $urandom_range(0, 255),
                $urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF));
      else
        add_req(REQ_DISPATCH, $urandom_range(0, 7), $urandom_range(0, 255),
                $urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF));
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (req_q.size() != 0 || in_tvalid || sched_replies.size() != 0) @(posedge clk);
    repeat (2 * SLOTS + 4) @(posedge clk);

    $display("Requests: %0d create, %0d delete, %0d tick, %0d dispatch; %0d results checked.",
             kind_seen[REQ_CREATE], kind_seen[REQ_DELETE], kind_seen[REQ_TICK],
             kind_seen[REQ_DISPATCH], n_checked);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
